// ===== src/pbcq_pkg.sv =====
// ----------------------------------------------------------------------------
// pbcq_pkg: shared types and constants of the PWM beacon capture qualifier
// Widths, reset values, register indexes and the records that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package pbcq_pkg;

  localparam int CHANNELS   = 6;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W    = 3;
  localparam int TS_W    = 32;
  localparam int LEN_W   = 16;
  localparam int PER_W   = 17;
  localparam int CFG_W   = 17;
  localparam int PROD_W  = CFG_W + PER_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] PERIOD_MIN_RST = 17'd0;
  localparam logic [CFG_W-1:0] PERIOD_MAX_RST = 17'd131071;
  localparam logic [CFG_W-1:0] DUTY_MIN_RST   = 17'd0;
  localparam logic [CFG_W-1:0] DUTY_MAX_RST   = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MIN = 2'd0,
    CFG_PERIOD_MAX = 2'd1,
    CFG_DUTY_MIN   = 2'd2,
    CFG_DUTY_MAX   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] period_min;
    logic [CFG_W-1:0] period_max;
    logic [CFG_W-1:0] duty_min;
    logic [CFG_W-1:0] duty_max;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            rising_edge;
    logic [TS_W-1:0] timestamp_us;
    logic            capture_enable;
  } evt_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [LEN_W-1:0] high_us;
    logic [LEN_W-1:0] low_us;
    logic [PER_W-1:0] period_us;
  } meas_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [LEN_W-1:0] high_us;
    logic [LEN_W-1:0] low_us;
    logic [PER_W-1:0] period_us;
    logic             freq_ok;
    logic             duty_ok;
    logic             valid_res;
  } res_t;

endpackage

// ===== src/pbcq_if.sv =====
// ----------------------------------------------------------------------------
// pbcq_if: edge-event and result channels
// Valid/ready channels; a beat moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface pbcq_in_if;
  logic                        valid;
  logic                        ready;
  logic [pbcq_pkg::CH_W-1:0]   channel;
  logic                        rising_edge;
  logic [pbcq_pkg::TS_W-1:0]   timestamp_us;
  logic                        capture_enable;

  modport source (output valid, channel, rising_edge, timestamp_us, capture_enable,
                  input ready);
  modport sink (input valid, channel, rising_edge, timestamp_us, capture_enable,
                output ready);
endinterface

interface pbcq_out_if;
  logic                        valid;
  logic                        ready;
  logic [pbcq_pkg::CH_W-1:0]   out_channel;
  logic [pbcq_pkg::LEN_W-1:0]  high_us;
  logic [pbcq_pkg::LEN_W-1:0]  low_us;
  logic [pbcq_pkg::PER_W-1:0]  period_us;
  logic                        freq_ok;
  logic                        duty_ok;
  logic                        valid_res;

  modport source (output valid, out_channel, high_us, low_us, period_us, freq_ok,
                  duty_ok, valid_res, input ready);
  modport sink (input valid, out_channel, high_us, low_us, period_us, freq_ok,
                duty_ok, valid_res, output ready);
endinterface

// ===== src/pbcq_chan_state.sv =====
// ----------------------------------------------------------------------------
// pbcq_chan_state: per-channel edge times and latched durations
// Computes high, low and period for one event and commits the update.
// ----------------------------------------------------------------------------
module pbcq_chan_state (
  input  logic              clk,
  input  logic              rst_n,
  input  pbcq_pkg::evt_t    evt,
  input  logic              commit,
  output pbcq_pkg::meas_t   meas
);

  logic [pbcq_pkg::TS_W-1:0]  rise_r [pbcq_pkg::CHANNELS];
  logic [pbcq_pkg::TS_W-1:0]  fall_r [pbcq_pkg::CHANNELS];
  logic [pbcq_pkg::LEN_W-1:0] high_r [pbcq_pkg::CHANNELS];
  logic [pbcq_pkg::LEN_W-1:0] low_r  [pbcq_pkg::CHANNELS];

  logic [pbcq_pkg::CHAN_IDX_W-1:0] idx;
  logic                            in_range;
  logic                            rec_rise;
  logic                            rec_fall;
  logic [pbcq_pkg::LEN_W-1:0]      high_nxt;
  logic [pbcq_pkg::LEN_W-1:0]      low_nxt;
  logic [pbcq_pkg::LEN_W-1:0]      high_eff;
  logic [pbcq_pkg::LEN_W-1:0]      low_eff;

  assign idx      = pbcq_pkg::CHAN_IDX_W'(evt.channel);
  assign in_range = 32'(evt.channel) < 32'(pbcq_pkg::CHANNELS);
  assign rec_rise = in_range && evt.capture_enable && evt.rising_edge;
  assign rec_fall = in_range && evt.capture_enable && !evt.rising_edge;

  always_comb begin
    high_nxt = '0;
    low_nxt  = '0;
    high_eff = '0;
    low_eff  = '0;
    if (in_range) begin
      // wrap the 32-bit difference down to 16 bits
      low_nxt  = pbcq_pkg::LEN_W'(evt.timestamp_us - fall_r[idx]);
      high_nxt = pbcq_pkg::LEN_W'(evt.timestamp_us - rise_r[idx]);
      high_eff = rec_fall ? high_nxt : high_r[idx];
      low_eff  = rec_rise ? low_nxt  : low_r[idx];
    end
  end

  assign meas.channel   = evt.channel;
  assign meas.high_us   = high_eff;
  assign meas.low_us    = low_eff;
  assign meas.period_us = {1'b0, high_eff} + {1'b0, low_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pbcq_pkg::CHANNELS; i++) begin
        rise_r[i] <= '0;
        fall_r[i] <= '0;
        high_r[i] <= '0;
        low_r[i]  <= '0;
      end
    end else if (commit) begin
      if (rec_rise) begin
        rise_r[idx] <= evt.timestamp_us;
        low_r[idx]  <= low_nxt;
      end
      if (rec_fall) begin
        fall_r[idx] <= evt.timestamp_us;
        high_r[idx] <= high_nxt;
      end
    end
  end

endmodule

// ===== src/pbcq_qualify.sv =====
// ----------------------------------------------------------------------------
// pbcq_qualify: period and duty window checks
// Compares the period against its window and low/period against the Q1.16
// duty window by cross-multiplication.
// ----------------------------------------------------------------------------
module pbcq_qualify (
  input  pbcq_pkg::meas_t  meas,
  input  pbcq_pkg::cfg_t   cfg,
  output pbcq_pkg::res_t   res
);

  logic [pbcq_pkg::PROD_W-1:0] scaled;
  logic [pbcq_pkg::PROD_W-1:0] lo_bound;
  logic [pbcq_pkg::PROD_W-1:0] hi_bound;
  logic                        freq_ok;
  logic                        duty_ok;

  assign scaled   = pbcq_pkg::PROD_W'({meas.low_us, 16'h0000});
  assign lo_bound = pbcq_pkg::PROD_W'(cfg.duty_min) * pbcq_pkg::PROD_W'(meas.period_us);
  assign hi_bound = pbcq_pkg::PROD_W'(cfg.duty_max) * pbcq_pkg::PROD_W'(meas.period_us);

  assign freq_ok = (meas.period_us > cfg.period_min) && (meas.period_us < cfg.period_max);
  assign duty_ok = (meas.period_us != '0) && (scaled > lo_bound) && (scaled < hi_bound);

  assign res.out_channel = meas.channel;
  assign res.high_us     = meas.high_us;
  assign res.low_us      = meas.low_us;
  assign res.period_us   = meas.period_us;
  assign res.freq_ok     = freq_ok;
  assign res.duty_ok     = duty_ok;
  assign res.valid_res   = freq_ok && duty_ok;

endmodule

// ===== src/pwm_beacon_capture_qualifier.sv =====
// ----------------------------------------------------------------------------
// pwm_beacon_capture_qualifier: PWM input capture with period/duty window
// Per-channel high/low time capture from timestamped edges, with a period
// window and a low-time duty window that qualify each measurement.
// ----------------------------------------------------------------------------
// Each beat on in_bus is one edge of one capture channel. The block takes one
// beat every clock cycle while in_bus.ready is high and returns one result beat
// per edge, in order, on out_bus. The beat goes through an input register, a
// register after the per-channel state update (which commits as the beat
// leaves the input register, so a following edge on the same channel sees it
// at once), and the result register after the window checks; the two 17x17
// cross-multiplies of the duty check sit in the last stage. A stall on out_bus
// backs up through the three stages, and in_bus.ready drops only when all of
// them hold a beat. Edges on channels at or above CHANNELS leave the state
// alone and report zero lengths and flags. Write the window registers through
// cfg_* only while no beat is in flight.
// ----------------------------------------------------------------------------
module pwm_beacon_capture_qualifier (
  input  logic                                clk,
  input  logic                                rst_n,
  pbcq_in_if.sink                             in_bus,
  pbcq_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [pbcq_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [pbcq_pkg::CFG_W-1:0]          cfg_wdata
);

  // window registers
  pbcq_pkg::cfg_t  cfg_r;

  // pipeline stages
  pbcq_pkg::evt_t  evt_r;
  logic            evt_vld_r;
  pbcq_pkg::meas_t meas_r;
  logic            meas_vld_r;
  pbcq_pkg::res_t  res_r;
  logic            res_vld_r;

  pbcq_pkg::evt_t  evt_in;
  pbcq_pkg::meas_t meas_nxt;
  pbcq_pkg::res_t  res_nxt;

  logic            res_rdy;
  logic            meas_rdy;
  logic            evt_rdy;

  // ready ripples back from the result register
  assign res_rdy  = !res_vld_r  || out_bus.ready;
  assign meas_rdy = !meas_vld_r || res_rdy;
  assign evt_rdy  = !evt_vld_r  || meas_rdy;

  assign in_bus.ready = evt_rdy;

  assign evt_in.channel        = in_bus.channel;
  assign evt_in.rising_edge    = in_bus.rising_edge;
  assign evt_in.timestamp_us   = in_bus.timestamp_us;
  assign evt_in.capture_enable = in_bus.capture_enable;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_min <= pbcq_pkg::PERIOD_MIN_RST;
      cfg_r.period_max <= pbcq_pkg::PERIOD_MAX_RST;
      cfg_r.duty_min   <= pbcq_pkg::DUTY_MIN_RST;
      cfg_r.duty_max   <= pbcq_pkg::DUTY_MAX_RST;
    end else if (cfg_we) begin
      unique case (pbcq_pkg::cfg_idx_t'(cfg_idx))
        pbcq_pkg::CFG_PERIOD_MIN: cfg_r.period_min <= cfg_wdata;
        pbcq_pkg::CFG_PERIOD_MAX: cfg_r.period_max <= cfg_wdata;
        pbcq_pkg::CFG_DUTY_MIN:   cfg_r.duty_min   <= cfg_wdata;
        pbcq_pkg::CFG_DUTY_MAX:   cfg_r.duty_max   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: capture the edge beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else if (evt_rdy) begin
      evt_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_rdy && in_bus.valid) begin
      evt_r <= evt_in;
    end
  end

  // stage 2: per-channel update; commit only as the beat moves on
  pbcq_chan_state u_chan_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .evt    (evt_r),
    .commit (evt_vld_r && meas_rdy),
    .meas   (meas_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_vld_r <= 1'b0;
    end else if (meas_rdy) begin
      meas_vld_r <= evt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_rdy && evt_vld_r) begin
      meas_r <= meas_nxt;
    end
  end

  // stage 3: window checks into the result register
  pbcq_qualify u_qualify (
    .meas (meas_r),
    .cfg  (cfg_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_rdy) begin
      res_vld_r <= meas_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && meas_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid       = res_vld_r;
  assign out_bus.out_channel = res_r.out_channel;
  assign out_bus.high_us     = res_r.high_us;
  assign out_bus.low_us      = res_r.low_us;
  assign out_bus.period_us   = res_r.period_us;
  assign out_bus.freq_ok     = res_r.freq_ok;
  assign out_bus.duty_ok     = res_r.duty_ok;
  assign out_bus.valid_res   = res_r.valid_res;

`ifndef SYNTHESIS
  // an accepted beat always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> evt_vld_r)
    else $error("accepted beat not captured");

  // the period carried forward is the sum of the two durations
  a_period_sum: assert property (@(posedge clk) disable iff (!rst_n)
    meas_vld_r |-> meas_r.period_us == ({1'b0, meas_r.high_us} + {1'b0, meas_r.low_us}))
    else $error("period is not high plus low");

  // a zero period never qualifies
  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && res_r.period_us == '0 |-> !res_r.freq_ok && !res_r.duty_ok)
    else $error("zero period qualified");

  // a stalled result register holds its beat
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && !out_bus.ready |=> res_vld_r && $stable(res_r))
    else $error("result changed under stall");
`endif

endmodule

// ===== verif/tb_pwm_beacon_capture_qualifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_beacon_capture_qualifier: self-checking bench for the capture block
// Drives timestamped edge beats with random gaps and output stalls, tracks
// the per-channel capture state and window settings in a scoreboard, and
// checks every result beat field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb_pwm_beacon_capture_qualifier;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the channel state and the window registers, plus
  // the queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class capture_scoreboard;
    logic [pbcq_pkg::CFG_W-1:0] per_lo_bound;
    logic [pbcq_pkg::CFG_W-1:0] per_hi_bound;
    logic [pbcq_pkg::CFG_W-1:0] duty_lo_bound;
    logic [pbcq_pkg::CFG_W-1:0] duty_hi_bound;
    logic [pbcq_pkg::TS_W-1:0]  rise_at [pbcq_pkg::CHANNELS];
    logic [pbcq_pkg::TS_W-1:0]  fall_at [pbcq_pkg::CHANNELS];
    logic [pbcq_pkg::LEN_W-1:0] high_len [pbcq_pkg::CHANNELS];
    logic [pbcq_pkg::LEN_W-1:0] low_len [pbcq_pkg::CHANNELS];
    pbcq_pkg::res_t             owed_results [$];
    int                         errors;

    function void clear();
      per_lo_bound  = pbcq_pkg::PERIOD_MIN_RST;
      per_hi_bound  = pbcq_pkg::PERIOD_MAX_RST;
      duty_lo_bound = pbcq_pkg::DUTY_MIN_RST;
      duty_hi_bound = pbcq_pkg::DUTY_MAX_RST;
      for (int i = 0; i < pbcq_pkg::CHANNELS; i++) begin
        rise_at[i]  = '0;
        fall_at[i]  = '0;
        high_len[i] = '0;
        low_len[i]  = '0;
      end
      owed_results.delete();
      errors = 0;
    endfunction

    function void write_window(pbcq_pkg::cfg_idx_t idx, logic [pbcq_pkg::CFG_W-1:0] val);
      case (idx)
        pbcq_pkg::CFG_PERIOD_MIN: per_lo_bound  = val;
        pbcq_pkg::CFG_PERIOD_MAX: per_hi_bound  = val;
        pbcq_pkg::CFG_DUTY_MIN:   duty_lo_bound = val;
        pbcq_pkg::CFG_DUTY_MAX:   duty_hi_bound = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted edge to the channel state and queue its measurement.
    function void note_edge(pbcq_pkg::evt_t e);
      pbcq_pkg::res_t r;
      int             ch;
      logic [63:0]    scaled;
      logic [63:0]    per_w;
      r = '0;
      ch = int'(e.channel);
      r.out_channel = e.channel;
      if (ch < pbcq_pkg::CHANNELS) begin
        if (e.capture_enable) begin
          if (e.rising_edge) begin
            rise_at[ch] = e.timestamp_us;
            low_len[ch] = pbcq_pkg::LEN_W'(e.timestamp_us - fall_at[ch]);
          end else begin
            fall_at[ch]  = e.timestamp_us;
            high_len[ch] = pbcq_pkg::LEN_W'(e.timestamp_us - rise_at[ch]);
          end
        end
        r.high_us   = high_len[ch];
        r.low_us    = low_len[ch];
        r.period_us = pbcq_pkg::PER_W'(high_len[ch]) + pbcq_pkg::PER_W'(low_len[ch]);
        r.freq_ok   = (r.period_us > per_lo_bound) && (r.period_us < per_hi_bound);
        if (r.period_us != '0) begin
          scaled    = 64'(low_len[ch]) << 16;
          per_w     = 64'(r.period_us);
          r.duty_ok = (scaled > 64'(duty_lo_bound) * per_w) &&
                      (scaled < 64'(duty_hi_bound) * per_w);
        end
        r.valid_res = r.freq_ok && r.duty_ok;
      end
      owed_results.push_back(r);
    endfunction

    function void field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pbcq_pkg::res_t got);
      pbcq_pkg::res_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, actual %p",
                 $time, got);
        return;
      end
      want = owed_results.pop_front();
      field_diff("out_channel", 32'(want.out_channel), 32'(got.out_channel));
      field_diff("high_us",     32'(want.high_us),     32'(got.high_us));
      field_diff("low_us",      32'(want.low_us),      32'(got.low_us));
      field_diff("period_us",   32'(want.period_us),   32'(got.period_us));
      field_diff("freq_ok",     32'(want.freq_ok),     32'(got.freq_ok));
      field_diff("duty_ok",     32'(want.duty_ok),     32'(got.duty_ok));
      field_diff("valid_res",   32'(want.valid_res),   32'(got.valid_res));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [pbcq_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [pbcq_pkg::CFG_W-1:0]     cfg_wdata;

  pbcq_in_if  in_if ();
  pbcq_out_if out_if ();

  capture_scoreboard sb;

  // Per-channel timeline of the stimulus: the last edge time and level, so
  // that most edges form clean alternating pulse trains.
  logic [pbcq_pkg::TS_W-1:0] trk_now  [8];
  bit                        trk_high [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pwm_beacon_capture_qualifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_if),
    .out_bus   (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Result side: check every beat that moves, sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(pbcq_pkg::res_t'{out_if.out_channel, out_if.high_us,
                                       out_if.low_us, out_if.period_us,
                                       out_if.freq_ok, out_if.duty_ok,
                                       out_if.valid_res});
    end
  end

  // Output backpressure: alternate stretches of always-ready, random
  // per-cycle stalls and long hard stalls so that gaps hit every pipe stage.
  initial begin
    int kind;
    int span;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        span = $urandom_range(20, 150);
        repeat (span) @(negedge clk) out_if.ready = 1'b1;
      end else if (kind < 8) begin
        span = $urandom_range(20, 150);
        repeat (span) @(negedge clk) out_if.ready = ($urandom_range(0, 3) != 0);
      end else begin
        span = $urandom_range(5, 40);
        repeat (span) @(negedge clk) out_if.ready = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one beat at the falling edge and hold it until it is taken.
  task automatic send_edge(input pbcq_pkg::evt_t e);
    @(negedge clk);
    in_if.valid          = 1'b1;
    in_if.channel        = e.channel;
    in_if.rising_edge    = e.rising_edge;
    in_if.timestamp_us   = e.timestamp_us;
    in_if.capture_enable = e.capture_enable;
    do @(posedge clk); while (!in_if.ready);
    sb.note_edge(e);
  endtask

  // Mostly back-to-back beats, some short gaps, a few long ones.
  task automatic idle_gap();
    int k;
    int n;
    k = $urandom_range(0, 99);
    if (k < 60) n = 0;
    else if (k < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) @(negedge clk) in_if.valid = 1'b0;
  endtask

  task automatic send_fields(input int ch, input bit rising,
                             input logic [pbcq_pkg::TS_W-1:0] ts, input bit en);
    pbcq_pkg::evt_t e;
    e.channel        = pbcq_pkg::CH_W'(ch);
    e.rising_edge    = rising;
    e.timestamp_us   = ts;
    e.capture_enable = en;
    send_edge(e);
    idle_gap();
  endtask

  // Drop valid and hold until every owed result is back, then let the pipe
  // settle.
  task automatic wait_drain();
    @(negedge clk) in_if.valid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input pbcq_pkg::cfg_idx_t idx,
                              input logic [pbcq_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_window(idx, val);
    @(negedge clk) cfg_we = 1'b0;
  endtask

  task automatic set_windows(input int pmin, input int pmax, input int dmin,
                             input int dmax);
    write_window(pbcq_pkg::CFG_PERIOD_MIN, pbcq_pkg::CFG_W'(pmin));
    write_window(pbcq_pkg::CFG_PERIOD_MAX, pbcq_pkg::CFG_W'(pmax));
    write_window(pbcq_pkg::CFG_DUTY_MIN,   pbcq_pkg::CFG_W'(dmin));
    write_window(pbcq_pkg::CFG_DUTY_MAX,   pbcq_pkg::CFG_W'(dmax));
  endtask

  // Random traffic: mostly alternating pulse trains per channel with
  // high/low lengths from the given base up to base plus spread, the rest noise,
  // repeated levels with wild gaps, and beats on channels that do not exist.
  task automatic run_traffic(input int count, input int base_hi, input int base_lo,
                             input int spread, input bit pause_mid);
    int             done;
    int             k;
    int             ch;
    bit             paused;
    pbcq_pkg::evt_t e;
    done   = 0;
    paused = 1'b0;
    // Start each train at a random time so the timeline wraps now and then.
    for (int i = 0; i < 8; i++) trk_now[i] = $urandom;
    while (done < count) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        ch = $urandom_range(0, pbcq_pkg::CHANNELS - 1);
        e.rising_edge    = !trk_high[ch];
        trk_now[ch]     += (e.rising_edge ? base_lo : base_hi) + $urandom_range(0, spread);
        trk_high[ch]     = e.rising_edge;
        e.channel        = pbcq_pkg::CH_W'(ch);
        e.timestamp_us   = trk_now[ch];
        e.capture_enable = ($urandom_range(0, 19) != 0);
      end else if (k < 88) begin
        e.channel        = pbcq_pkg::CH_W'($urandom_range(0, 7));
        e.rising_edge    = 1'($urandom_range(0, 1));
        e.timestamp_us   = $urandom;
        e.capture_enable = 1'($urandom_range(0, 1));
      end else if (k < 94) begin
        // Repeat the last level after an arbitrary, possibly huge, gap.
        ch = $urandom_range(0, pbcq_pkg::CHANNELS - 1);
        trk_now[ch]     += $urandom_range(0, 200000);
        e.channel        = pbcq_pkg::CH_W'(ch);
        e.rising_edge    = trk_high[ch];
        e.timestamp_us   = trk_now[ch];
        e.capture_enable = 1'b1;
      end else begin
        e.channel        = pbcq_pkg::CH_W'($urandom_range(pbcq_pkg::CHANNELS, 7));
        e.rising_edge    = 1'($urandom_range(0, 1));
        e.timestamp_us   = $urandom;
        e.capture_enable = 1'($urandom_range(0, 1));
      end
      send_edge(e);
      idle_gap();
      done++;
      // Hold the sender once until the block has emptied.
      if (pause_mid && !paused && done >= count / 2) begin
        paused = 1'b1;
        wait_drain();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new;
    sb.clear();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = pbcq_pkg::CFG_PERIOD_MIN;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.channel        = '0;
    in_if.rising_edge    = 1'b0;
    in_if.timestamp_us   = '0;
    in_if.capture_enable = 1'b0;
    for (int i = 0; i < 8; i++) begin
      trk_now[i]  = '0;
      trk_high[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed edges under the reset windows.
    send_fields(0, 1'b0, 32'd0, 1'b0);             // capture off, zero period
    send_fields(0, 1'b1, 32'd1000, 1'b1);          // low only: fraction exactly one
    send_fields(0, 1'b0, 32'd1300, 1'b1);
    send_fields(0, 1'b1, 32'd2000, 1'b1);
    send_fields(0, 1'b1, 32'hFFFF_FFFF, 1'b0);     // capture off keeps stored times
    send_fields(1, 1'b1, 32'hFFFF_FF00, 1'b1);
    send_fields(1, 1'b0, 32'h0000_0100, 1'b1);     // timestamp wraps
    send_fields(6, 1'b1, $urandom, 1'b1);          // channels past the last one
    send_fields(7, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_fields(7, 1'b1, 32'd0, 1'b0);
    send_fields(5, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_fields(5, 1'b0, 32'hFFFF_FFFF, 1'b1);     // zero high time
    send_fields(5, 1'b1, 32'h0001_FFFE, 1'b1);     // low time cut to all ones
    send_fields(5, 1'b0, 32'h0002_FFFD, 1'b1);     // both lengths maxed
    send_fields(2, 1'b1, $urandom, 1'b1);
    send_fields(3, 1'b0, $urandom, 1'b1);
    send_fields(4, 1'b1, $urandom, 1'b1);
    send_fields(4, 1'b0, $urandom, 1'b0);
    run_traffic(200, 300, 700, 200, 1'b0);
    wait_drain();

    // Mid-size window straddled by the traffic; pause once halfway.
    set_windows(800, 1200, 32'h4000, 32'hC000);
    run_traffic(200, 300, 600, 300, 1'b1);
    wait_drain();

    // Inverted extremes: nothing may qualify.
    set_windows(131071, 0, 65536, 0);
    run_traffic(200, 500, 500, 400, 1'b0);
    wait_drain();

    // Widest windows with lengths near the 16-bit limit.
    set_windows(0, 131071, 0, 65536);
    run_traffic(200, 30000, 30000, 35535, 1'b0);
    wait_drain();

    // Tight duty window around one half, short periods.
    set_windows(20, 60, 32767, 32769);
    run_traffic(200, 20, 20, 4, 1'b0);
    wait_drain();

    // Random windows.
    begin
      int pmin;
      int dmin;
      pmin = $urandom_range(0, 1500);
      dmin = $urandom_range(0, 40000);
      set_windows(pmin, pmin + $urandom_range(0, 2500), dmin,
                  dmin + $urandom_range(0, 65536 - dmin));
    end
    run_traffic(200, 200, 400, 800, 1'b1);
    wait_drain();

    // Leave room for any stray beat, then report.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("** pwm_beacon_capture_qualifier: PASSED **");
    end else begin
      $display("** pwm_beacon_capture_qualifier: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** pwm_beacon_capture_qualifier: FAILED **");
    $finish;
  end

endmodule
